// ===== design/http_request_byte_classifier_unit_assert.svh =====
// ---------------------------------------------------------------------------
// HTTP request byte classifier: assertion macros
// Shared property forms for the classifier's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_CLASSIFIER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_BYTE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRBC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hrbc_pkg.sv =====
// ---------------------------------------------------------------------------
// HTTP request byte classifier package
// Phase codes, byte kinds, delimiter characters and beat layout widths.
// ---------------------------------------------------------------------------
`default_nettype none

package hrbc_pkg;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned RDATA_W = 24;
   localparam int unsigned RUSER_W = 4;

   localparam logic [CH_W-1:0]  CH_SP   = 8'h20;
   localparam logic [CH_W-1:0]  CH_CR   = 8'h0D;
   localparam logic [CH_W-1:0]  CH_LF   = 8'h0A;
   localparam logic [CH_W-1:0]  CH_COL  = 8'h3A;
   localparam logic [CH_W-1:0]  CH_NUL  = 8'h00;
   localparam logic [CNT_W-1:0] HDR_MAX = 8'hFF;

   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_PATH    = 4'd1,
      PH_VERSION = 4'd2,
      PH_VER_CR  = 4'd3,
      PH_LINE    = 4'd4,
      PH_NAME    = 4'd5,
      PH_VSKIP   = 4'd6,
      PH_VALUE   = 4'd7,
      PH_HDR_CR  = 4'd8,
      PH_END_CR  = 4'd9,
      PH_BODY    = 4'd10,
      PH_BAD     = 4'd11
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      K_SKIP    = 3'd0,
      K_METHOD  = 3'd1,
      K_PATH    = 3'd2,
      K_VERSION = 3'd3,
      K_NAME    = 3'd4,
      K_VALUE   = 3'd5,
      K_BODY    = 3'd6
   } kind_type;

endpackage

`default_nettype wire

// ===== design/http_request_byte_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// HTTP request byte classifier
// Tags each byte of an HTTP request by its role and reports a verdict at the
// end-of-message byte.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request byte per beat in req_tdata[7:0]; a zero byte
//   ends the message. rsp_* returns exactly one beat per request beat, in
//   order, with the byte, its kind and a header-start flag. On the zero byte
//   rsp_tlast is high and the beat carries the ok verdict and the header
//   count instead of a byte.
//   The accepted byte lands in the input register and the phase machine
//   fills the result register, which drives rsp_tvalid. Throughput is one
//   byte per cycle while the receiver holds rsp_tready high.
//   When the receiver holds rsp_tready low, the result register holds its
//   beat and the input register still takes one more byte; after that
//   req_tready drops until the result beat is taken.
//   Synchronous reset empties both registers and returns the parser to the
//   start of the request line with a zero header count.
// ---------------------------------------------------------------------------
`default_nettype none

module http_request_byte_classifier_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   input  wire logic [hrbc_pkg::CH_W-1:0]    req_tdata,  // [7:0] ch
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   output      logic [hrbc_pkg::RDATA_W-1:0] rsp_tdata,  // [7:0] byte_out, [8] ok,
                                                         // [16:9] header_total, rest 0
   output      logic [hrbc_pkg::RUSER_W-1:0] rsp_tuser,  // [2:0] kind, [3] header_start
   output      logic                         rsp_tlast   // done_res
);

   // Input register.
   logic                        in_vld_ff;
   logic [hrbc_pkg::CH_W-1:0]   in_ch_ff;

   // Parser state.
   hrbc_pkg::phase_type         phase_ff, phase_in;
   logic                        meth_ne_ff, meth_ne_in;
   logic                        path_ne_ff, path_ne_in;
   logic [hrbc_pkg::CNT_W-1:0]  hdr_cnt_ff, hdr_cnt_in;

   // Result register.
   logic                        out_vld_ff;
   hrbc_pkg::kind_type          out_kind_ff, kind_in;
   logic [hrbc_pkg::CH_W-1:0]   out_byte_ff, byte_in;
   logic                        out_hs_ff, hs_in;
   logic                        out_done_ff, done_in;
   logic                        out_ok_ff, ok_in;
   logic [hrbc_pkg::CNT_W-1:0]  out_total_ff, total_in;

   logic out_free;
   logic advance;
   logic is_nul, is_sp, is_cr, is_lf, is_col;
   logic line_done;
   logic hdr_inc;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   assign is_nul = (in_ch_ff == hrbc_pkg::CH_NUL);
   assign is_sp  = (in_ch_ff == hrbc_pkg::CH_SP);
   assign is_cr  = (in_ch_ff == hrbc_pkg::CH_CR);
   assign is_lf  = (in_ch_ff == hrbc_pkg::CH_LF);
   assign is_col = (in_ch_ff == hrbc_pkg::CH_COL);

   assign line_done = (phase_ff >= hrbc_pkg::PH_VER_CR) && (phase_ff <= hrbc_pkg::PH_BODY);

   // A header line begins when a line-start phase sees a byte that is not
   // a line terminator.
   always_comb begin
      hdr_inc = 1'b0;
      unique case (phase_ff)
         hrbc_pkg::PH_VER_CR, hrbc_pkg::PH_HDR_CR: hdr_inc = !is_lf && !is_cr;
         hrbc_pkg::PH_LINE:                        hdr_inc = !is_lf && !is_cr;
         default:                                  hdr_inc = 1'b0;
      endcase
   end

   // Next-state logic.
   always_comb begin
      phase_in   = phase_ff;
      meth_ne_in = meth_ne_ff;
      path_ne_in = path_ne_ff;
      hdr_cnt_in = hdr_cnt_ff;
      if (is_nul) begin
         phase_in   = hrbc_pkg::PH_METHOD;
         meth_ne_in = 1'b0;
         path_ne_in = 1'b0;
         hdr_cnt_in = '0;
      end else begin
         if (hdr_inc && (hdr_cnt_ff != hrbc_pkg::HDR_MAX)) begin
            hdr_cnt_in = hdr_cnt_ff + 8'd1;
         end
         unique case (phase_ff)
            hrbc_pkg::PH_METHOD: begin
               if (is_sp)               phase_in = hrbc_pkg::PH_PATH;
               else if (is_cr || is_lf) phase_in = hrbc_pkg::PH_BAD;
               else                     meth_ne_in = 1'b1;
            end
            hrbc_pkg::PH_PATH: begin
               if (is_sp)               phase_in = hrbc_pkg::PH_VERSION;
               else if (is_cr || is_lf) phase_in = hrbc_pkg::PH_BAD;
               else                     path_ne_in = 1'b1;
            end
            hrbc_pkg::PH_VERSION: begin
               if (is_cr)      phase_in = hrbc_pkg::PH_VER_CR;
               else if (is_lf) phase_in = hrbc_pkg::PH_LINE;
            end
            hrbc_pkg::PH_VER_CR, hrbc_pkg::PH_HDR_CR, hrbc_pkg::PH_LINE: begin
               // After a CR, the LF is absorbed; another CR ends the headers and any
               // other byte starts a fresh line.
               if (is_lf && phase_ff != hrbc_pkg::PH_LINE) phase_in = hrbc_pkg::PH_LINE;
               else if (is_cr)  phase_in = hrbc_pkg::PH_END_CR;
               else if (is_lf)  phase_in = hrbc_pkg::PH_BODY;
               else if (is_col) phase_in = hrbc_pkg::PH_VSKIP;
               else             phase_in = hrbc_pkg::PH_NAME;
            end
            hrbc_pkg::PH_NAME: begin
               if (is_col)     phase_in = hrbc_pkg::PH_VSKIP;
               else if (is_cr) phase_in = hrbc_pkg::PH_HDR_CR;
               else if (is_lf) phase_in = hrbc_pkg::PH_LINE;
            end
            hrbc_pkg::PH_VSKIP, hrbc_pkg::PH_VALUE: begin
               if (is_cr)      phase_in = hrbc_pkg::PH_HDR_CR;
               else if (is_lf) phase_in = hrbc_pkg::PH_LINE;
               else if (!(is_sp && phase_ff == hrbc_pkg::PH_VSKIP)) begin
                  phase_in = hrbc_pkg::PH_VALUE;
               end
            end
            hrbc_pkg::PH_END_CR: phase_in = hrbc_pkg::PH_BODY;
            hrbc_pkg::PH_BODY:   phase_in = hrbc_pkg::PH_BODY;
            default:             phase_in = hrbc_pkg::PH_BAD;
         endcase
      end
   end

   // Result logic.
   always_comb begin
      kind_in  = hrbc_pkg::K_SKIP;
      hs_in    = 1'b0;
      byte_in  = in_ch_ff;
      done_in  = is_nul;
      ok_in    = 1'b0;
      total_in = '0;
      if (is_nul) begin
         byte_in  = '0;
         ok_in    = line_done && meth_ne_ff && path_ne_ff;
         total_in = hdr_cnt_ff;
      end else begin
         hs_in = hdr_inc;
         unique case (phase_ff)
            hrbc_pkg::PH_METHOD: begin
               if (!is_sp && !is_cr && !is_lf) kind_in = hrbc_pkg::K_METHOD;
            end
            hrbc_pkg::PH_PATH: begin
               if (!is_sp && !is_cr && !is_lf) kind_in = hrbc_pkg::K_PATH;
            end
            hrbc_pkg::PH_VERSION: begin
               if (!is_cr && !is_lf) kind_in = hrbc_pkg::K_VERSION;
            end
            hrbc_pkg::PH_VER_CR, hrbc_pkg::PH_HDR_CR, hrbc_pkg::PH_LINE, hrbc_pkg::PH_NAME: begin
               if (!is_cr && !is_lf && !is_col) kind_in = hrbc_pkg::K_NAME;
            end
            hrbc_pkg::PH_VSKIP, hrbc_pkg::PH_VALUE: begin
               if (!is_cr && !is_lf && !(is_sp && phase_ff == hrbc_pkg::PH_VSKIP)) begin
                  kind_in = hrbc_pkg::K_VALUE;
               end
            end
            hrbc_pkg::PH_END_CR: begin
               if (!is_lf) kind_in = hrbc_pkg::K_BODY;
            end
            hrbc_pkg::PH_BODY: kind_in = hrbc_pkg::K_BODY;
            default:           kind_in = hrbc_pkg::K_SKIP;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= hrbc_pkg::PH_METHOD;
         meth_ne_ff <= 1'b0;
         path_ne_ff <= 1'b0;
         hdr_cnt_ff <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (out_free) begin
            out_vld_ff <= in_vld_ff;
         end
         if (advance) begin
            phase_ff   <= phase_in;
            meth_ne_ff <= meth_ne_in;
            path_ne_ff <= path_ne_in;
            hdr_cnt_ff <= hdr_cnt_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff <= req_tdata;
      end
      if (advance) begin
         out_kind_ff  <= kind_in;
         out_byte_ff  <= byte_in;
         out_hs_ff    <= hs_in;
         out_done_ff  <= done_in;
         out_ok_ff    <= ok_in;
         out_total_ff <= total_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_total_ff, out_ok_ff, out_byte_ff};
   assign rsp_tuser  = {out_hs_ff, out_kind_ff};
   assign rsp_tlast  = out_done_ff;

`include "http_request_byte_classifier_unit_assert.svh"

   `HRBC_ASSERT_SAME(a_done_is_skip, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == '0 && rsp_tdata[7:0] == '0, "done beat carries a byte or kind")
   `HRBC_ASSERT_SAME(a_summary_on_done, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[16:8] == '0, "summary fields set on a data beat")
   `HRBC_ASSERT_NEXT(a_end_resets, clock, reset, advance && is_nul, phase_ff == hrbc_pkg::PH_METHOD && hdr_cnt_ff == '0 && !meth_ne_ff && !path_ne_ff, "parser not back at start after end of message")
   `HRBC_ASSERT_NEXT(a_count_monotonic, clock, reset, advance && !is_nul, hdr_cnt_ff >= $past(hdr_cnt_ff), "header count fell inside a message")

endmodule

`default_nettype wire
